// File: rtl/smdm_pkg.sv
// shared constants and types for the signed multiply / divide / remainder unit
// no dependencies
package smdm_pkg;

    localparam int DEFAULT_DATA_WIDTH = 32;

    localparam int FUNC_W = 2;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_MUL = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DIV = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REM = 2'd2;

    // control from the sequencer to the bit-serial engine
    typedef struct packed {
        logic load;    // take new operand magnitudes
        logic step;    // advance one bit
        logic is_div;  // restoring division step instead of shift-add
    } t_eng_ctrl;

endpackage

// File: rtl/signed_mul_div_mod_unit.sv
// top level of the signed multiply / divide / remainder unit: sequencer and sign handling
// depends on smdm_pkg and smdm_engine
//
// usage
//   command channel: drive i_func, i_operand_a, i_operand_b and raise start;
//   the item is taken at a rising edge where start is high and busy is low
//   func: multiply (low bits of signed product), divide (quotient truncated
//   toward zero), remainder (sign of the dividend); unused code gives 0
//   zero divisor gives 0 for divide and remainder; overflow wraps, no flag
//   result channel: o_result_value is valid for exactly one cycle with
//   o_valid high; the receiver cannot stall, so nothing backs up
//   sequence: the accept edge leads to one magnitude state, DATA_WIDTH bit
//   steps in the run state and one sign fixup state that loads the output
//   register and raises o_valid; busy drops in the cycle o_valid is high,
//   so a new item can be taken while o_valid is high
//   the rate is set by the bit-serial engine, one product or quotient bit
//   per cycle through a DATA_WIDTH adder or a DATA_WIDTH + 1 subtractor
//   reset (synchronous, active low) returns the sequencer to idle and drops
//   o_valid; an item in flight is lost
module signed_mul_div_mod_unit #(
    parameter int DATA_WIDTH = smdm_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [smdm_pkg::FUNC_W-1:0] i_func,
    input  logic signed [DATA_WIDTH-1:0] i_operand_a,
    input  logic signed [DATA_WIDTH-1:0] i_operand_b,
    output logic                        o_valid,
    output logic signed [DATA_WIDTH-1:0] o_result_value
);
    import smdm_pkg::*;

    localparam int CNT_W = $clog2(DATA_WIDTH);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MAG  = 2'd1;
    localparam logic [1:0] S_RUN  = 2'd2;
    localparam logic [1:0] S_FIX  = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_valid, n_valid;

    // latched item
    logic [FUNC_W-1:0]     r_func;
    logic [DATA_WIDTH-1:0] r_a, r_b;
    logic                  r_bzero;
    logic [DATA_WIDTH-1:0] r_result, n_result;

    logic                  w_accept;
    logic                  w_sign_a, w_sign_b;
    logic [DATA_WIDTH-1:0] w_mag_a, w_mag_b;
    logic [DATA_WIDTH-1:0] w_acc, w_quo;
    logic [DATA_WIDTH-1:0] w_val;
    logic                  w_neg;
    t_eng_ctrl             w_ctrl;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    assign w_sign_a = r_a[DATA_WIDTH-1];
    assign w_sign_b = r_b[DATA_WIDTH-1];
    // magnitudes; the most negative value maps onto itself, read as unsigned
    assign w_mag_a  = w_sign_a ? (~r_a + 1'b1) : r_a;
    assign w_mag_b  = w_sign_b ? (~r_b + 1'b1) : r_b;

    always_comb begin
        w_ctrl.load   = (r_state == S_MAG);
        w_ctrl.step   = (r_state == S_RUN);
        w_ctrl.is_div = (r_func != FUNC_MUL);
    end

    smdm_engine #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_engine (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_mag_a (w_mag_a),
        .i_mag_b (w_mag_b),
        .o_acc   (w_acc),
        .o_quo   (w_quo)
    );

    // sign fixup and result selection
    always_comb begin
        w_val = '0;
        w_neg = 1'b0;
        case (r_func)
            FUNC_MUL: begin
                w_val = w_acc;
                w_neg = w_sign_a ^ w_sign_b;
            end
            FUNC_DIV: begin
                w_val = r_bzero ? '0 : w_quo;
                w_neg = w_sign_a ^ w_sign_b;
            end
            FUNC_REM: begin
                w_val = r_bzero ? '0 : w_acc;
                w_neg = w_sign_a;
            end
            default: begin
                w_val = '0;
                w_neg = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_valid  = 1'b0;
        n_result = r_result;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_MAG;
                end
            end
            S_MAG: begin
                n_cnt   = LAST_STEP;
                n_state = S_RUN;
            end
            S_RUN: begin
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                n_result = w_neg ? (~w_val + 1'b1) : w_val;
                n_valid  = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    // item payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= i_func;
            r_a    <= i_operand_a;
            r_b    <= i_operand_b;
        end
        if (r_state == S_MAG) begin
            r_bzero <= (r_b == '0);
        end
        r_result <= n_result;
    end

    assign o_valid        = r_valid;
    assign o_result_value = r_result;

endmodule

// File: rtl/smdm_engine.sv
// bit-serial engine: one shift-add multiply or restoring division bit per step cycle
// depends on smdm_pkg
module smdm_engine #(
    parameter int DATA_WIDTH = smdm_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic                  i_clk,
    input  smdm_pkg::t_eng_ctrl   i_ctrl,
    input  logic [DATA_WIDTH-1:0] i_mag_a,
    input  logic [DATA_WIDTH-1:0] i_mag_b,
    output logic [DATA_WIDTH-1:0] o_acc,
    output logic [DATA_WIDTH-1:0] o_quo
);
    import smdm_pkg::*;

    logic [DATA_WIDTH-1:0] r_acc, n_acc;  // product accumulator or partial remainder
    logic [DATA_WIDTH-1:0] r_x, n_x;      // multiplicand, or dividend shifting out msb first
    logic [DATA_WIDTH-1:0] r_y, n_y;      // multiplier shifting out lsb first, or divisor
    logic [DATA_WIDTH-1:0] r_q, n_q;      // quotient bits shifting in

    logic [DATA_WIDTH:0]   w_trial;
    logic [DATA_WIDTH:0]   w_diff;

    always_comb begin
        n_acc = r_acc;
        n_x   = r_x;
        n_y   = r_y;
        n_q   = r_q;
        // partial remainder shifted left with the next dividend bit, carry kept on top
        w_trial = {r_acc, r_x[DATA_WIDTH-1]};
        w_diff  = w_trial - {1'b0, r_y};
        if (i_ctrl.load) begin
            n_acc = '0;
            n_x   = i_mag_a;
            n_y   = i_mag_b;
            n_q   = '0;
        end else if (i_ctrl.step) begin
            if (i_ctrl.is_div) begin
                n_x = {r_x[DATA_WIDTH-2:0], 1'b0};
                if (!w_diff[DATA_WIDTH]) begin
                    n_acc = w_diff[DATA_WIDTH-1:0];
                    n_q   = {r_q[DATA_WIDTH-2:0], 1'b1};
                end else begin
                    n_acc = w_trial[DATA_WIDTH-1:0];
                    n_q   = {r_q[DATA_WIDTH-2:0], 1'b0};
                end
            end else begin
                if (r_y[0]) begin
                    n_acc = r_acc + r_x;
                end
                n_x = {r_x[DATA_WIDTH-2:0], 1'b0};
                n_y = {1'b0, r_y[DATA_WIDTH-1:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
        r_q   <= n_q;
    end

    assign o_acc = r_acc;
    assign o_quo = r_q;

endmodule
